### design/fvc_pkg.sv
package fvc_pkg;

  localparam int MAX_TAPS    = 16;
  localparam int TAP_W       = 5;
  localparam int TAP_IDX_W   = 4;
  localparam int COEFF_WORDS = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int GROUPS      = 4;
  localparam int GROUP_SIZE  = MAX_TAPS / GROUPS;

  localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_0   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_1   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_2   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_3   = 3'd4;

  localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 5'd16;
  localparam logic [TAP_W-1:0] TAP_COUNT_MAX   = 5'd16;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [15:0] coeff_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [33:0] psum_t;
  typedef logic signed [35:0] acc_t;

  typedef sample_t window_t [MAX_TAPS];
  typedef coeff_t  coeffs_t [MAX_TAPS];

endpackage

### design/fvc_channels.sv
interface fvc_in_if;
  import fvc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_block;

  modport source (output valid, output sample, output start_block, input ready);
  modport sink (input valid, input sample, input start_block, output ready);
endinterface

interface fvc_out_if;
  import fvc_pkg::*;

  logic valid;
  logic ready;
  acc_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

### design/fvc_dot.sv
module fvc_dot (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  fvc_pkg::window_t window_next,
  input  fvc_pkg::coeffs_t coeff_al,
  output logic             can_take,
  fvc_out_if.source        results
);
  import fvc_pkg::*;

  prod_t prod [MAX_TAPS];
  psum_t psum [GROUPS];
  logic  prod_valid;
  logic  psum_valid;
  logic  out_valid;
  acc_t  filtered;

  logic  out_ready;
  logic  psum_ready;
  logic  prod_ready;

  psum_t psum_next [GROUPS];
  acc_t  filtered_next;

  assign out_ready  = !out_valid || results.ready;
  assign psum_ready = !psum_valid || out_ready;
  assign prod_ready = !prod_valid || psum_ready;
  assign can_take   = prod_ready;

  assign results.valid    = out_valid;
  assign results.filtered = filtered;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      psum_next[g] = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        psum_next[g] = psum_next[g] + psum_t'(prod[g*GROUP_SIZE + i]);
      end
    end
  end

  always_comb begin
    filtered_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      filtered_next = filtered_next + acc_t'(psum[g]);
    end
  end

  // product lanes (one multiplier per window slot), group sums and output register
  always_ff @(posedge clk) begin
    if (prod_ready) begin
      for (int j = 0; j < MAX_TAPS; j++) begin
        prod[j] <= prod_t'(window_next[j]) * prod_t'(coeff_al[j]);
      end
    end
    if (psum_ready) begin
      psum <= psum_next;
    end
    if (out_ready) begin
      filtered <= filtered_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      psum_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= take;
      end
      if (psum_ready) begin
        psum_valid <= prod_valid;
      end
      if (out_ready) begin
        out_valid <= psum_valid;
      end
    end
  end

endmodule

### design/fir_valid_convolution.sv
// Streaming FIR, valid-convolution form, exact Q6.30 sum of up to 16 taps.
// Pipeline: a sample word taken with a result goes through the product lanes,
// the group adders and the output register, in that order.
// Throughput: one sample word per cycle; the pipeline only holds on output stall.
// Reset (synchronous, active high): tap_count 16, coefficients and window zero,
// fill count zero, pipeline empty.
module fir_valid_convolution (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [fvc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [fvc_pkg::CFG_DATA_W-1:0]         cfg_data,
  fvc_in_if.sink                                 samples,
  fvc_out_if.source                              results
);
  import fvc_pkg::*;

  logic [TAP_W-1:0]      tap_count;
  logic [CFG_DATA_W-1:0] coeff_words [COEFF_WORDS];
  window_t               window;
  logic [TAP_W-1:0]      fill_count;

  window_t               window_next;
  logic [TAP_W-1:0]      fill_count_next;
  logic [TAP_W-1:0]      fill_base;
  logic [TAP_W-1:0]      taps_eff;
  coeffs_t               coeff_al_next;
  logic [TAP_W-1:0]      tap_src;
  logic                  accept;
  logic                  has_result;
  logic                  can_take;

  assign samples.ready = can_take;
  assign accept        = samples.valid && can_take;

  always_comb begin
    if (tap_count == '0) begin
      taps_eff = TAP_W'(1);
    end else if (tap_count > TAP_COUNT_MAX) begin
      taps_eff = TAP_COUNT_MAX;
    end else begin
      taps_eff = tap_count;
    end
  end

  // window slot j (0 = newest) meets h[taps-1-j]
  always_comb begin
    tap_src = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      tap_src = taps_eff - TAP_W'(1) - TAP_W'(j);
      if (TAP_W'(j) < taps_eff) begin
        coeff_al_next[j] = coeff_t'(coeff_words[tap_src[TAP_IDX_W-1:2]]
                                    >> (16 * tap_src[1:0]));
      end else begin
        coeff_al_next[j] = '0;
      end
    end
  end

  always_comb begin
    window_next[0] = samples.sample;
    for (int j = 1; j < MAX_TAPS; j++) begin
      window_next[j] = window[j-1];
    end
  end

  always_comb begin
    fill_base = samples.start_block ? '0 : fill_count;
    if (fill_base < TAP_COUNT_MAX) begin
      fill_count_next = fill_base + TAP_W'(1);
    end else begin
      fill_count_next = fill_base;
    end
    has_result = (fill_count_next >= taps_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= TAP_COUNT_RESET;
      fill_count <= '0;
      for (int w = 0; w < COEFF_WORDS; w++) begin
        coeff_words[w] <= '0;
      end
      for (int j = 0; j < MAX_TAPS; j++) begin
        window[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TAP_COUNT: tap_count      <= cfg_data[TAP_W-1:0];
          REG_COEFF_0:   coeff_words[0] <= cfg_data;
          REG_COEFF_1:   coeff_words[1] <= cfg_data;
          REG_COEFF_2:   coeff_words[2] <= cfg_data;
          REG_COEFF_3:   coeff_words[3] <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        window     <= window_next;
        fill_count <= fill_count_next;
      end
    end
  end

  fvc_dot u_dot (
    .clk         (clk),
    .rst         (rst),
    .take        (accept && has_result),
    .window_next (window_next),
    .coeff_al    (coeff_al_next),
    .can_take    (can_take),
    .results     (results)
  );

endmodule

### bench/tb_fir_valid_convolution.sv
module tb_fir_valid_convolution;
  timeunit 1ns;
  timeprecision 1ps;

  import fvc_pkg::*;

  localparam int PIPE_LATENCY = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 120;
  localparam int MAX_SHOWN    = 30;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_COEFF_3 + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = '1;

  localparam logic [CFG_DATA_W-1:0] COEFF_ALL_NEG = 64'h8000_8000_8000_8000;
  localparam logic [CFG_DATA_W-1:0] COEFF_ALL_POS = 64'h7FFF_7FFF_7FFF_7FFF;

  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;

  // tap settings per random phase: zero, oversized and both ends included
  localparam int TAP_PLAN [PHASES] = '{1, 16, 0, 31, 17, 5, 12, 2, 8, 16, 3, 20};

  typedef struct packed {
    sample_t sample;
    logic    start_block;
  } sample_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fvc_in_if  sample_ch ();
  fvc_out_if result_ch ();

  fir_valid_convolution i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  // filter model state
  logic [TAP_W-1:0]      tap_reg;
  logic [CFG_DATA_W-1:0] coeff_reg [COEFF_WORDS];
  window_t               fir_window;
  int                    fill;

  sample_word_t pending_words [$];
  acc_t         expected_outputs [$];
  sample_word_t next_word;

  bit word_taken;
  int send_gap;
  int recv_stall;
  int idle_pct;
  int cycle_count;
  int errors;
  int words_in;
  int results_seen;

  function automatic int eff_taps(input logic [TAP_W-1:0] t);
    if (t == 0) return 1;
    if (t > MAX_TAPS) return MAX_TAPS;
    return t;
  endfunction

  function automatic bit fir_step(input sample_word_t w, output acc_t y);
    int taps;
    logic signed [63:0] sum;
    coeff_t h;
    taps = eff_taps(tap_reg);
    if (w.start_block) fill = 0;
    for (int k = MAX_TAPS - 1; k > 0; k--) fir_window[k] = fir_window[k-1];
    fir_window[0] = w.sample;
    if (fill < MAX_TAPS) fill++;
    y = '0;
    if (fill < taps) return 1'b0;
    sum = 0;
    for (int k = 0; k < taps; k++) begin
      h = coeff_reg[k/4][16*(k%4) +: 16];
      sum += h * fir_window[taps-1-k];
    end
    y = sum[35:0];
    return 1'b1;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return $urandom_range(0, 1) ? sample_t'(0) : sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    acc_t y;
    acc_t want;
    cycle_count++;
    if (rst) begin
      tap_reg = TAP_COUNT_RESET;
      foreach (coeff_reg[i]) coeff_reg[i] = '0;
      foreach (fir_window[i]) fir_window[i] = '0;
      fill = 0;
      expected_outputs.delete();
      word_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TAP_COUNT) tap_reg = cfg_data[TAP_W-1:0];
        else if (cfg_index >= REG_COEFF_0 && cfg_index <= REG_COEFF_3)
          coeff_reg[2'(cfg_index - REG_COEFF_0)] = cfg_data;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        word_taken = 1'b1;
        words_in++;
        if (fir_step('{sample_ch.sample, sample_ch.start_block}, y))
          expected_outputs.push_back(y);
      end
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: unexpected filtered word %0d", $time, result_ch.filtered);
        end else begin
          want = expected_outputs.pop_front();
          if (result_ch.filtered !== want) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("%0t: filtered mismatch, expected %0d actual %0d",
                       $time, want, result_ch.filtered);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      result_ch.ready <= 1'b0;
      send_gap = 0;
      recv_stall = 0;
    end else begin
      if (!sample_ch.valid || word_taken) begin
        word_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          sample_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          sample_ch.valid       <= 1'b1;
          sample_ch.sample      <= next_word.sample;
          sample_ch.start_block <= next_word.start_block;
          send_gap = gap_len();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        recv_stall = gap_len();
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_taps(input logic [TAP_W-1:0] t);
    logic [CFG_DATA_W-1:0] d;
    d = {$urandom, $urandom};
    d[TAP_W-1:0] = t;
    write_reg(REG_TAP_COUNT, d);
  endtask

  task automatic push_word(input sample_t s, input logic sb);
    sample_word_t w;
    w.sample = s;
    w.start_block = sb;
    pending_words.push_back(w);
  endtask

  // wait until the pipe is empty before touching registers
  task automatic drain();
    while (pending_words.size() != 0 || sample_ch.valid || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic queue_blocks(input int n_words, input int taps);
    int left;
    int len;
    left = n_words;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) len = taps + $urandom_range(0, 40);
      else len = $urandom_range(1, taps);
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        push_word(pick_sample(),
                  (i == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 199) == 0));
      left -= len;
    end
  endtask

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_fir_valid_convolution: FAIL");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] word_data;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TAP_COUNT;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    sample_ch.start_block = 1'b0;
    result_ch.ready = 1'b0;
    errors = 0;
    words_in = 0;
    results_seen = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full 16-tap window at the negative extremes, then a restart
    write_taps(TAP_COUNT_MAX);
    write_reg(REG_COEFF_0, COEFF_ALL_NEG);
    write_reg(REG_COEFF_1, COEFF_ALL_NEG);
    write_reg(REG_COEFF_2, COEFF_ALL_NEG);
    write_reg(REG_COEFF_3, COEFF_ALL_NEG);
    for (int i = 0; i < MAX_TAPS; i++) push_word(SAMPLE_MIN, i == 0);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain();

    // zero tap count acts as one tap; unused indexes must not land anywhere
    write_taps('0);
    write_reg(REG_COEFF_0, 64'h0000_0000_0000_7FFF);
    write_reg(REG_UNUSED_FIRST, '1);
    write_reg(REG_UNUSED_LAST, '1);
    push_word(SAMPLE_MIN, 1'b1);
    push_word(SAMPLE_MAX, 1'b0);
    push_word('0, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p % 3 == 0) ? 0 : $urandom_range(15, 60);
      write_taps(TAP_W'(TAP_PLAN[p]));
      for (int r = 0; r < COEFF_WORDS; r++) begin
        case (p % 5)
          1: word_data = COEFF_ALL_NEG;
          3: word_data = COEFF_ALL_POS;
          default: word_data = {$urandom, $urandom};
        endcase
        write_reg(REG_COEFF_0 + r[CFG_INDEX_W-1:0], word_data);
      end
      if (p % 4 == 2) write_reg(REG_UNUSED_FIRST + 1'b1, {$urandom, $urandom});
      queue_blocks(PHASE_WORDS, eff_taps(TAP_W'(TAP_PLAN[p])));
      drain();
    end

    repeat (PIPE_LATENCY * 4) @(negedge clk);
    $display("Sent %0d sample words, checked %0d filtered words over %0d tap settings",
             words_in, results_seen, PHASES + 2);
    $display("Swept zero and oversized tap counts, coefficient extremes, block restarts");
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("tb_fir_valid_convolution: PASS");
    end else begin
      $display("tb_fir_valid_convolution: FAIL");
    end
    $finish;
  end

endmodule
